// File: design/vdplt_pkg.sv
// Shared types and constants for the video processor port and line timing block.
// No dependencies; imported by every module of the block.
package vdplt_pkg;

    localparam int VRAM_DEPTH = 16384;
    localparam int VRAM_AW    = 14;

    typedef logic [2:0] t_op;
    localparam t_op OP_CTRL_WR  = 3'd0;
    localparam t_op OP_DATA_WR  = 3'd1;
    localparam t_op OP_DATA_RD  = 3'd2;
    localparam t_op OP_STAT_RD  = 3'd3;
    localparam t_op OP_VCNT_RD  = 3'd4;
    localparam t_op OP_HCNT_RD  = 3'd5;
    localparam t_op OP_ADVANCE  = 3'd6;

    // Control word command code, bits 15:14.
    localparam logic [1:0] CMD_VRAM_RD = 2'd0;
    localparam logic [1:0] CMD_VRAM_WR = 2'd1;
    localparam logic [1:0] CMD_REG_WR  = 2'd2;
    localparam logic [1:0] CMD_CRAM_WR = 2'd3;

    localparam logic [3:0] REG_MODE1 = 4'd0;
    localparam logic [3:0] REG_MODE2 = 4'd1;
    localparam logic [3:0] REG_LINE  = 4'd10;

    localparam logic [7:0] REG_MODE1_RST = 8'h36;
    localparam logic [7:0] REG_MODE2_RST = 8'h80;
    localparam logic [7:0] REG_LINE_RST  = 8'hFF;

    localparam logic [1:0] HGT_192 = 2'd0;
    localparam logic [1:0] HGT_224 = 2'd1;
    localparam logic [1:0] HGT_240 = 2'd2;

    localparam logic [4:0] STATUS_LOW_ONES = 5'h1F;

    localparam logic [8:0] LINES_NTSC = 9'd262;
    localparam logic [8:0] LINES_PAL  = 9'd313;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [7:0] cycles;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt;
        logic       frame_done;
    } t_rsp;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } t_vram_req;

    typedef struct packed {
        logic       advance;
        logic [7:0] cycles;
        logic       status_clr;
        logic       ldc_load;
        logic [7:0] ldc_value;
    } t_tim_ctl;

    typedef struct packed {
        logic [7:0] reg0;
        logic [7:0] reg1;
        logic [7:0] reg10;
        logic [1:0] height;
        logic       pal;
    } t_tim_cfg;

    typedef struct packed {
        logic [7:0] vcount;
        logic [7:0] hcount;
        logic       frame_flag;
        logic       irq;
        logic       frame_done;
    } t_tim_stat;

endpackage

// File: design/vdplt_vram.sv
// Video RAM: single-port synchronous memory with a registered read.
// Sweeps every entry to zero after reset. Uses vdplt_pkg.
module vdplt_vram import vdplt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_vram_req i_req,
    output logic [7:0] o_rdata,
    output logic      o_clearing
);

    logic [7:0]         r_mem [VRAM_DEPTH];
    logic [7:0]         r_rdata;
    logic               r_clr_busy;
    logic [VRAM_AW-1:0] r_clr_addr;

    logic               mem_we;
    logic [VRAM_AW-1:0] mem_waddr;
    logic [7:0]         mem_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == VRAM_AW'(VRAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign mem_we    = r_clr_busy | i_req.we;
    assign mem_waddr = r_clr_busy ? r_clr_addr : i_req.addr;
    assign mem_wdata = r_clr_busy ? 8'h00 : i_req.wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clr_busy;

endmodule

// File: design/vdplt_timing.sv
// H/V counters, scanline, line interrupt counter and frame flag.
// Uses vdplt_pkg; one line is processed per advance that reaches the line length.
module vdplt_timing import vdplt_pkg::*; #(
    parameter int LINE_CYCLES = 228
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tim_ctl  i_ctl,
    input  t_tim_cfg  i_cfg,
    output t_tim_stat o_stat
);

    localparam int         SUM_MAX   = 510;
    localparam int         MAX_WRAPS = SUM_MAX / LINE_CYCLES;
    localparam logic [8:0] LC9       = 9'(LINE_CYCLES);

    logic [7:0] r_hcount, n_hcount;
    logic [7:0] r_vcount, n_vcount;
    logic [8:0] r_line,   n_line;
    logic [7:0] r_ldc,    n_ldc;
    logic       r_flag,   n_flag;

    logic [8:0] sum;
    logic [7:0] hmod;
    logic [8:0] lines;
    logic [8:0] jump_on;
    logic [7:0] jump_to;
    logic [8:0] total;
    logic       irq;
    logic       frame;

    always_comb begin
        sum  = {1'b0, r_hcount} + {1'b0, i_ctl.cycles};
        hmod = sum[7:0];
        for (int k = 1; k <= MAX_WRAPS; k++) begin
            if (sum >= 9'(k * LINE_CYCLES)) begin
                hmod = 8'(sum - 9'(k * LINE_CYCLES));
            end
        end

        unique case (i_cfg.height)
            HGT_224: begin
                lines   = 9'd224;
                jump_on = i_cfg.pal ? 9'd256 : 9'd235;
                jump_to = i_cfg.pal ? 8'hCB  : 8'd229;
            end
            HGT_240: begin
                lines   = 9'd240;
                jump_on = 9'd256;
                jump_to = i_cfg.pal ? 8'hD3 : 8'd0;
            end
            default: begin
                lines   = 9'd192;
                jump_on = i_cfg.pal ? 9'd243 : 9'd219;
                jump_to = i_cfg.pal ? 8'd186 : 8'd213;
            end
        endcase
        total = i_cfg.pal ? LINES_PAL : LINES_NTSC;

        n_hcount = r_hcount;
        n_vcount = r_vcount;
        n_line   = r_line;
        n_ldc    = r_ldc;
        n_flag   = r_flag;
        irq      = 1'b0;
        frame    = 1'b0;

        if (i_ctl.ldc_load) begin
            n_ldc = i_ctl.ldc_value;
        end
        if (i_ctl.status_clr) begin
            n_flag = 1'b0;
        end

        if (i_ctl.advance) begin
            if (sum < LC9) begin
                n_hcount = sum[7:0];
            end else begin
                n_hcount = hmod;
                n_vcount = (r_line == jump_on) ? jump_to : r_vcount + 8'd1;

                if (r_line <= lines) begin
                    if (r_ldc == 8'd0) begin
                        n_ldc = i_cfg.reg10;
                        irq   = i_cfg.reg0[4];
                    end else begin
                        n_ldc = r_ldc - 8'd1;
                    end
                end else begin
                    n_ldc = i_cfg.reg10;
                end

                if (r_line == lines) begin
                    n_flag = 1'b1;
                end
                if (r_line == lines + 9'd1 && i_cfg.reg1[5]) begin
                    irq = 1'b1;
                end

                if ({1'b0, r_line} + 10'd1 >= {1'b0, total}) begin
                    n_line = '0;
                    frame  = 1'b1;
                end else begin
                    n_line = r_line + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= '0;
            r_vcount <= '0;
            r_line   <= '0;
            r_ldc    <= '0;
            r_flag   <= 1'b0;
        end else begin
            r_hcount <= n_hcount;
            r_vcount <= n_vcount;
            r_line   <= n_line;
            r_ldc    <= n_ldc;
            r_flag   <= n_flag;
        end
    end

    assign o_stat = '{vcount:     r_vcount,
                      hcount:     r_hcount,
                      frame_flag: r_flag,
                      irq:        irq,
                      frame_done: frame};

endmodule

// File: design/vdplt_outq.sv
// Two-entry response queue between the request side and the response port.
// Uses vdplt_pkg for the response type.
module vdplt_outq import vdplt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rsp i_rsp,
    input  logic i_stall,
    output logic o_valid,
    output t_rsp o_rsp,
    output logic o_full
);

    t_rsp       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_rsp   = r_slot[r_rd_ptr];
    assign pop     = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/vdp_port_and_line_timing.sv
// Responses pass through a two-entry queue; o_req_stall is high while it is full.
// Throughput: one request per cycle while o_req_stall is low.
// Prefetch data comes from the VRAM read register, loaded when the read is issued.
// Reset: synchronous, active low; afterwards every VRAM entry is cleared to zero,
// and o_req_stall is high meanwhile. Configuration writes are taken at any time.
module vdp_port_and_line_timing import vdplt_pkg::*; #(
    parameter int LINE_CYCLES = 228
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    logic               r_pending,  n_pending;
    logic [7:0]         r_latch_lo, n_latch_lo;
    logic [VRAM_AW-1:0] r_addr,     n_addr;
    logic               r_cram,     n_cram;
    logic [7:0]         r_prefetch, n_prefetch;
    logic               r_pf_ram,   n_pf_ram;
    logic [7:0]         r_reg0,     n_reg0;
    logic [7:0]         r_reg1,     n_reg1;
    logic [7:0]         r_reg10,    n_reg10;
    logic [1:0]         r_height,   n_height;
    logic               r_pal;

    logic       accept;
    logic       q_full;
    logic       clearing;
    logic [7:0] vram_rdata;
    logic [7:0] pf_now;
    t_vram_req  vram_req;
    t_tim_ctl   tim_ctl;
    t_tim_cfg   tim_cfg;
    t_tim_stat  tim_stat;
    t_rsp       rsp;
    logic [7:0] rd;

    assign o_req_stall = q_full | clearing;
    assign accept      = i_req_valid & ~o_req_stall;
    assign pf_now      = r_pf_ram ? vram_rdata : r_prefetch;

    always_comb begin
        n_pending  = r_pending;
        n_latch_lo = r_latch_lo;
        n_addr     = r_addr;
        n_cram     = r_cram;
        n_prefetch = r_prefetch;
        n_pf_ram   = r_pf_ram;
        n_reg0     = r_reg0;
        n_reg1     = r_reg1;
        n_reg10    = r_reg10;
        n_height   = r_height;
        vram_req   = '0;
        tim_ctl    = '0;
        rd         = 8'h00;

        if (accept) begin
            unique case (i_req.op)
                OP_CTRL_WR: begin
                    if (!r_pending) begin
                        n_latch_lo = i_req.data;
                        n_pending  = 1'b1;
                        n_addr     = {r_addr[VRAM_AW-1:8], i_req.data};
                    end else begin
                        n_pending = 1'b0;
                        n_addr    = {i_req.data[5:0], r_latch_lo};
                        unique case (i_req.data[7:6])
                            CMD_VRAM_RD: begin
                                n_cram        = 1'b0;
                                vram_req.re   = 1'b1;
                                vram_req.addr = {i_req.data[5:0], r_latch_lo};
                                n_pf_ram      = 1'b1;
                                n_addr        = {i_req.data[5:0], r_latch_lo} + 1'b1;
                            end
                            CMD_VRAM_WR: begin
                                n_cram = 1'b0;
                            end
                            CMD_REG_WR: begin
                                priority if (i_req.data[3:0] == REG_MODE1) begin
                                    n_reg0 = r_latch_lo;
                                end else if (i_req.data[3:0] == REG_MODE2) begin
                                    n_reg1 = r_latch_lo;
                                    if (!r_reg0[1]) begin
                                        n_height = HGT_192;
                                    end else if (r_latch_lo[3]) begin
                                        n_height = HGT_240;
                                    end else if (r_latch_lo[4]) begin
                                        n_height = HGT_224;
                                    end else begin
                                        n_height = HGT_192;
                                    end
                                end else if (i_req.data[3:0] == REG_LINE) begin
                                    n_reg10           = r_latch_lo;
                                    tim_ctl.ldc_load  = 1'b1;
                                    tim_ctl.ldc_value = r_latch_lo;
                                end else begin
                                    n_reg10 = r_reg10;
                                end
                            end
                            CMD_CRAM_WR: begin
                                n_cram = 1'b1;
                            end
                            default: begin
                                n_cram = r_cram;
                            end
                        endcase
                    end
                end
                OP_DATA_WR: begin
                    n_pending      = 1'b0;
                    vram_req.we    = ~r_cram;
                    vram_req.addr  = r_addr;
                    vram_req.wdata = i_req.data;
                    n_addr         = r_addr + 1'b1;
                    n_prefetch     = i_req.data;
                    n_pf_ram       = 1'b0;
                end
                OP_DATA_RD: begin
                    n_pending     = 1'b0;
                    rd            = pf_now;
                    vram_req.re   = 1'b1;
                    vram_req.addr = r_addr;
                    n_addr        = r_addr + 1'b1;
                    n_pf_ram      = 1'b1;
                end
                OP_STAT_RD: begin
                    n_pending          = 1'b0;
                    rd                 = {tim_stat.frame_flag, 2'b00, STATUS_LOW_ONES};
                    tim_ctl.status_clr = 1'b1;
                end
                OP_VCNT_RD: begin
                    rd = tim_stat.vcount;
                end
                OP_HCNT_RD: begin
                    rd = tim_stat.hcount;
                end
                OP_ADVANCE: begin
                    tim_ctl.advance = 1'b1;
                    tim_ctl.cycles  = i_req.cycles;
                end
                default: begin
                    rd = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= 1'b0;
            r_latch_lo <= '0;
            r_addr     <= '0;
            r_cram     <= 1'b0;
            r_prefetch <= '0;
            r_pf_ram   <= 1'b0;
            r_reg0     <= REG_MODE1_RST;
            r_reg1     <= REG_MODE2_RST;
            r_reg10    <= REG_LINE_RST;
            r_height   <= HGT_192;
            r_pal      <= 1'b0;
        end else begin
            r_pending  <= n_pending;
            r_latch_lo <= n_latch_lo;
            r_addr     <= n_addr;
            r_cram     <= n_cram;
            r_prefetch <= n_prefetch;
            r_pf_ram   <= n_pf_ram;
            r_reg0     <= n_reg0;
            r_reg1     <= n_reg1;
            r_reg10    <= n_reg10;
            r_height   <= n_height;
            if (i_cfg_we) begin
                r_pal <= i_cfg_wdata;
            end
        end
    end

    assign tim_cfg = '{reg0:   r_reg0,
                       reg1:   r_reg1,
                       reg10:  r_reg10,
                       height: r_height,
                       pal:    r_pal};

    assign rsp = '{read_data:  rd,
                   interrupt:  tim_stat.irq,
                   frame_done: tim_stat.frame_done};

    vdplt_vram u_vram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (vram_req),
        .o_rdata    (vram_rdata),
        .o_clearing (clearing)
    );

    vdplt_timing #(
        .LINE_CYCLES (LINE_CYCLES)
    ) u_timing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tim_ctl),
        .i_cfg   (tim_cfg),
        .o_stat  (tim_stat)
    );

    vdplt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_rsp   (rsp),
        .i_stall (i_rsp_stall),
        .o_valid (o_rsp_valid),
        .o_rsp   (o_rsp),
        .o_full  (q_full)
    );

endmodule

// File: design/vdplt_checker.sv
// Port-level checks for vdp_port_and_line_timing, attached by the bind below.
// Uses vdplt_pkg for the response type.
module vdplt_checker import vdplt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_stall,
    input logic o_rsp_valid,
    input logic i_rsp_stall,
    input t_rsp o_rsp
);

    // held response must not change while stalled
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // timing flags only come with advance requests, which return no data
    a_flags_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.interrupt || o_rsp.frame_done) |-> o_rsp.read_data == 8'h00)
        else $error("read data with timing flags");

    // VRAM clear holds off requests right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_req_stall)
        else $error("request side open during VRAM clear");

    // a new response needs a request accepted in the cycle before
    a_rsp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !$past(o_rsp_valid) |-> $past(i_req_valid && !o_req_stall))
        else $error("response without request");

endmodule

bind vdp_port_and_line_timing vdplt_checker u_vdplt_checker (.*);

// File: dv/vdplt_port_scoreboard.sv
// Scoreboard for the video processor port and line timing block: predicts every response
// from the accepted requests and compares it, field by field, with what the block returns.
// Depends on vdplt_pkg for the request and response types and codes.
module vdplt_port_scoreboard import vdplt_pkg::*; #(
    parameter int LINE_CYCLES = 228
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_stall,
    input  t_req       i_req,
    input  logic       i_rsp_valid,
    input  logic       i_rsp_stall,
    input  t_rsp       i_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked,
    output int         o_irqs,
    output int         o_frames,
    output logic [8:0] o_line
);

    logic [7:0]  vram [0:VRAM_DEPTH-1];
    logic [7:0]  cram [0:31];
    logic [7:0]  regs [0:10];
    logic        pending_hi;
    logic [15:0] ctrl_word;
    logic [13:0] addr;
    logic        cram_mode;
    logic [7:0]  prefetch;
    logic [7:0]  status;
    logic [7:0]  line_ctr;
    logic [8:0]  line;
    logic [7:0]  vcnt;
    logic [7:0]  hcnt;
    logic [1:0]  height;
    logic        pal;
    t_rsp        rsp_due [$];
    t_rsp        due;
    t_rsp        want;

    task automatic clear_model();
        foreach (vram[i]) vram[i] = '0;
        foreach (cram[i]) cram[i] = '0;
        regs = '{REG_MODE1_RST, REG_MODE2_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB,
                 8'h00, 8'h00, 8'h00, REG_LINE_RST};
        pending_hi = 1'b0;
        ctrl_word  = '0;
        addr       = '0;
        cram_mode  = 1'b0;
        prefetch   = '0;
        status     = '0;
        line_ctr   = '0;
        line       = '0;
        vcnt       = '0;
        hcnt       = '0;
        height     = HGT_192;
        pal        = 1'b0;
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] value);
        if (idx > REG_LINE) return;
        regs[idx] = value;
        if (idx == REG_MODE2) begin
            if (!regs[REG_MODE1][1]) height = HGT_192;
            else if (value[3]) height = HGT_240;
            else if (value[4]) height = HGT_224;
            else height = HGT_192;
        end else if (idx == REG_LINE) begin
            line_ctr = value;
        end
    endtask

    task automatic control_byte(input logic [7:0] b);
        if (!pending_hi) begin
            ctrl_word  = {8'h00, b};
            pending_hi = 1'b1;
            addr       = {addr[13:8], b};
            return;
        end
        ctrl_word[15:8] = b;
        pending_hi      = 1'b0;
        addr            = ctrl_word[13:0];
        case (ctrl_word[15:14])
            CMD_VRAM_RD: begin
                cram_mode = 1'b0;
                prefetch  = vram[addr];
                addr      = addr + 1'b1;
            end
            CMD_VRAM_WR: cram_mode = 1'b0;
            CMD_REG_WR:  write_reg(ctrl_word[11:8], ctrl_word[7:0]);
            default:     cram_mode = 1'b1;
        endcase
    endtask

    task automatic advance_lines(input logic [7:0] cyc, output logic irq, output logic wrap);
        int h_sum;
        int lines_active;
        int jump_on;
        int jump_to;
        int lines_total;
        irq   = 1'b0;
        wrap  = 1'b0;
        h_sum = int'(hcnt) + int'(cyc);
        if (h_sum < LINE_CYCLES) begin
            hcnt = 8'(h_sum);
            return;
        end
        hcnt = 8'(h_sum % LINE_CYCLES);
        case (height)
            HGT_224: begin
                lines_active = 224;
                jump_on      = pal ? 256 : 235;
                jump_to      = pal ? 'hCB : 229;
            end
            HGT_240: begin
                lines_active = 240;
                jump_on      = 256;
                jump_to      = pal ? 'hD3 : 0;
            end
            default: begin
                lines_active = 192;
                jump_on      = pal ? 243 : 219;
                jump_to      = pal ? 186 : 213;
            end
        endcase
        if (int'(line) == jump_on) vcnt = 8'(jump_to);
        else vcnt = vcnt + 1'b1;
        if (int'(line) <= lines_active) begin
            if (line_ctr == 0) begin
                line_ctr = regs[REG_LINE];
                if (regs[REG_MODE1][4]) irq = 1'b1;
            end else begin
                line_ctr = line_ctr - 1'b1;
            end
        end else begin
            line_ctr = regs[REG_LINE];
        end
        if (int'(line) == lines_active) status[7] = 1'b1;
        if (int'(line) == lines_active + 1 && regs[REG_MODE2][5]) irq = 1'b1;
        lines_total = pal ? int'(LINES_PAL) : int'(LINES_NTSC);
        if (int'(line) + 1 >= lines_total) begin
            line = '0;
            wrap = 1'b1;
        end else begin
            line = line + 1'b1;
        end
    endtask

    task automatic predict_request(input t_req r, output t_rsp e);
        logic irq;
        logic wrap;
        e = '0;
        case (r.op)
            OP_CTRL_WR: control_byte(r.data);
            OP_DATA_WR: begin
                pending_hi = 1'b0;
                if (cram_mode) cram[addr[4:0]] = r.data;
                else vram[addr] = r.data;
                addr     = addr + 1'b1;
                prefetch = r.data;
            end
            OP_DATA_RD: begin
                pending_hi  = 1'b0;
                e.read_data = prefetch;
                prefetch    = vram[addr];
                addr        = addr + 1'b1;
            end
            OP_STAT_RD: begin
                pending_hi  = 1'b0;
                e.read_data = status | {3'b000, STATUS_LOW_ONES};
                status[7:5] = 3'b000;
            end
            OP_VCNT_RD: e.read_data = vcnt;
            OP_HCNT_RD: e.read_data = hcnt;
            OP_ADVANCE: begin
                advance_lines(r.cycles, irq, wrap);
                e.interrupt  = irq;
                e.frame_done = wrap;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
            rsp_due.delete();
        end else begin
            if (i_cfg_we) pal = i_cfg_wdata;
            if (i_rsp_valid && !i_rsp_stall) begin
                if (rsp_due.size() == 0) begin
                    $display("%0t: unexpected response, expected none actual %h", $time, i_rsp);
                    o_errors++;
                end else begin
                    want = rsp_due.pop_front();
                    o_checked++;
                    if (want.interrupt) o_irqs++;
                    if (want.frame_done) o_frames++;
                    if (i_rsp.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, i_rsp.read_data);
                        o_errors++;
                    end
                    if (i_rsp.interrupt !== want.interrupt) begin
                        $display("%0t: interrupt expected %b actual %b",
                                 $time, want.interrupt, i_rsp.interrupt);
                        o_errors++;
                    end
                    if (i_rsp.frame_done !== want.frame_done) begin
                        $display("%0t: frame_done expected %b actual %b",
                                 $time, want.frame_done, i_rsp.frame_done);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req, due);
                rsp_due.push_back(due);
            end
        end
        o_pending = rsp_due.size();
        o_line    = line;
    end

endmodule

// File: dv/vdp_port_and_line_timing_tb.sv
// Top of the port and line timing testbench: clock, reset, request and stall generation,
// video standard changes and the verdict. Depends on vdplt_pkg, the block and
// vdplt_port_scoreboard, which does all prediction and comparison.
module vdp_port_and_line_timing_tb;
    import vdplt_pkg::*;

    localparam int  LINE_CYCLES = 228;
    localparam t_op OP_UNUSED   = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    t_req       req;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    t_rsp       rsp;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       calm = 1'b0;
    int         errors;
    int         pending;
    int         checked;
    int         irqs;
    int         frames;
    logic [8:0] line;
    int         sent;
    int         switches;

    vdp_port_and_line_timing #(.LINE_CYCLES(LINE_CYCLES)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    vdplt_port_scoreboard #(.LINE_CYCLES(LINE_CYCLES)) u_score (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_stall (req_stall),
        .i_req       (req),
        .i_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .i_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_irqs      (irqs),
        .o_frames    (frames),
        .o_line      (line)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        rsp_stall <= !calm && ($urandom_range(99) < 8);
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send(input t_op op, input logic [7:0] data, input logic [7:0] cyc);
        t_req r;
        r.op     = op;
        r.data   = data;
        r.cycles = cyc;
        while (!calm && $urandom_range(99) < 8) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_standard(input logic pal_sel);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= pal_sel;
        @(negedge clk);
        cfg_we <= 1'b0;
        switches++;
    endtask

    task automatic random_item();
        int         pick;
        logic [1:0] cmd;
        logic [3:0] idx;
        logic [7:0] lo;
        logic [7:0] hi;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send(OP_ADVANCE, 8'($urandom),
                 ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(255, 150)));
        end else if (pick < 70) begin
            // well-formed two-byte control word, addresses kept mostly low
            cmd = 2'($urandom_range(3));
            lo  = 8'($urandom);
            if (cmd == CMD_REG_WR) begin
                idx = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
                if (idx == REG_LINE && $urandom_range(1) == 0) lo = 8'($urandom_range(3));
                hi = {CMD_REG_WR, 2'($urandom), idx};
            end else begin
                hi = {cmd, ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1))};
            end
            send(OP_CTRL_WR, lo, 8'($urandom));
            send(OP_CTRL_WR, hi, 8'($urandom));
        end else if (pick < 80) begin
            send(OP_DATA_WR, 8'($urandom), 8'($urandom));
        end else if (pick < 88) begin
            send(OP_DATA_RD, 8'($urandom), 8'($urandom));
        end else if (pick < 92) begin
            send(OP_STAT_RD, 8'($urandom), 8'($urandom));
        end else if (pick < 94) begin
            send(OP_VCNT_RD, 8'($urandom), 8'($urandom));
        end else if (pick < 96) begin
            send(OP_HCNT_RD, 8'($urandom), 8'($urandom));
        end else if (pick < 97) begin
            send(OP_UNUSED, 8'($urandom), 8'($urandom));
        end else begin
            // lone control byte leaves the pair out of step
            send(OP_CTRL_WR, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        sent      = 0;
        switches  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_standard(1'b0);

        send(OP_STAT_RD, 8'h00, 8'h00);
        send(OP_VCNT_RD, 8'hFF, 8'hFF);
        send(OP_HCNT_RD, 8'h00, 8'h00);
        send(OP_UNUSED,  8'hFF, 8'hFF);
        send(OP_CTRL_WR, 8'h00, 8'h00);
        send(OP_CTRL_WR, 8'h40, 8'h00);
        send(OP_DATA_WR, 8'hFF, 8'h00);
        send(OP_CTRL_WR, 8'h00, 8'h00);
        send(OP_CTRL_WR, 8'h00, 8'h00);
        send(OP_DATA_RD, 8'h00, 8'h00);
        send(OP_CTRL_WR, 8'hFF, 8'h00);
        send(OP_CTRL_WR, 8'hFF, 8'h00);
        send(OP_DATA_WR, 8'hAA, 8'h00);
        // counter read between the two control bytes keeps the pair intact
        send(OP_CTRL_WR, 8'h12, 8'h00);
        send(OP_VCNT_RD, 8'h00, 8'h00);
        send(OP_CTRL_WR, 8'h80, 8'h00);
        send(OP_CTRL_WR, 8'h28, 8'h00);
        send(OP_CTRL_WR, 8'h81, 8'h00);
        send(OP_CTRL_WR, 8'h00, 8'h00);
        send(OP_CTRL_WR, 8'h8A, 8'h00);
        send(OP_CTRL_WR, 8'h55, 8'h00);
        send(OP_CTRL_WR, 8'h8F, 8'h00);
        send(OP_CTRL_WR, 8'h77, 8'h00);
        send(OP_DATA_RD, 8'h00, 8'h00);
        send(OP_ADVANCE, 8'h00, 8'h00);
        send(OP_ADVANCE, 8'h00, 8'd227);
        send(OP_ADVANCE, 8'h00, 8'hFF);

        while (sent < 290) random_item();

        set_standard(1'b1);
        calm <= 1'b1;
        while (sent < 420) random_item();
        calm <= 1'b0;
        while (sent < 550) random_item();
        // park past the last NTSC line so the switch back must wrap on the next line
        while (line < 9'd263 || line > 9'd312) send(OP_ADVANCE, 8'h00, 8'(LINE_CYCLES));

        set_standard(1'b0);
        while (sent < 680) random_item();
        drain();
        while (sent < 810) random_item();

        set_standard(1'b1);
        while (sent < 1080) random_item();

        drain();
        $display("tb: %0d requests answered and checked, %0d interrupts, %0d frame wraps",
                 checked, irqs, frames);
        $display("tb: %0d video standard writes across NTSC and PAL", switches);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
